// ===== rtl/sfr_pkg.sv =====
package sfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;

    localparam int RUN_MAX = 64;
    localparam int RUN_W   = 7;
    localparam int IDX_W   = 6;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START   = 3'd0,
        CFG_ACK     = 3'd1,
        CFG_NACK    = 3'd2,
        CFG_EXACT   = 3'd3,
        CFG_ABOVE   = 3'd4,
        CFG_BELOW   = 3'd5,
        CFG_SEED    = 3'd6,
        CFG_TIMEOUT = 3'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        EV_ACK     = 3'd0,
        EV_NACK    = 3'd1,
        EV_BYTE    = 3'd2,
        EV_ERR     = 3'd3,
        EV_TIMEOUT = 3'd4
    } t_event;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        t_event           event_res;
        logic [7:0]       frame_byte;
        logic [IDX_W-1:0] byte_index;
        logic             last;
    } t_out;

    // cnt only meaningful for a frame run (ev == EV_BYTE)
    typedef struct packed {
        t_event           ev;
        logic [RUN_W-1:0] cnt;
    } t_cmd;

endpackage

// ===== rtl/serial_frame_receiver_top.sv =====
// Channel   Direction  Handshake          Payload
// input     in         i_push / o_full    i_in  (action, rx_byte)
// result    out        o_empty / i_pop    o_out (event_res, frame_byte, byte_index, last)
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One request is taken per cycle while o_full is low. After a frame checks out,
// o_full stays high until the back end has fetched the last byte of the run from
// the frame store; that fetch waits behind queued commands and a held result.
// A result passes through the command queue, the s1 register and the output register
// before it is on o_out.
// Reset is synchronous, active low; the frame store is not cleared.
// Outside a run, a held result blocks the front only once the command queue is full.
module serial_frame_receiver_top #(
    parameter int BUFFER_DEPTH = sfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  sfr_pkg::t_in                   i_in,
    output logic                           o_empty,
    input  logic                           i_pop,
    output sfr_pkg::t_out                  o_out
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          cmd_push;
    sfr_pkg::t_cmd cmd_in;
    logic          cmd_full;
    logic          cmd_pop;
    logic          cmd_empty;
    sfr_pkg::t_cmd cmd_head;
    logic          run_done;
    logic          run_pend;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    sfr_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_in       (i_in),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full),
        .i_run_done (run_done),
        .o_run_pend (run_pend),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    sfr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_head  (cmd_head)
    );

    sfr_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .o_run_done  (run_done),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_no_cmd_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd_push && cmd_full))
        else $error("command queue overflow");

    a_run_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_done |-> run_pend)
        else $error("run finished with no run pending");

    a_no_write_during_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !run_pend)
        else $error("frame store written while a run is being read");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_out.event_res != sfr_pkg::EV_BYTE)) |-> o_out.last)
        else $error("single event result without last");
`endif

endmodule

// ===== rtl/sfr_cmd_fifo.sv =====
module sfr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sfr_pkg::t_cmd o_head
);

    sfr_pkg::t_cmd                r_mem [sfr_pkg::CMD_DEPTH];
    logic [sfr_pkg::CMD_AW-1:0]   r_wp;
    logic [sfr_pkg::CMD_AW-1:0]   r_rp;
    logic [sfr_pkg::CMD_AW:0]     r_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_cnt == (sfr_pkg::CMD_AW + 1)'(sfr_pkg::CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== rtl/sfr_front.sv =====
module sfr_front #(
    parameter int BUFFER_DEPTH = sfr_pkg::BUFFER_DEPTH_DEF,
    localparam int AW = $clog2(BUFFER_DEPTH),
    localparam int FW = $clog2(BUFFER_DEPTH + 1),
    localparam int CW = (FW > 8) ? FW : 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  sfr_pkg::t_in                   i_in,
    output logic                           o_cmd_push,
    output sfr_pkg::t_cmd                  o_cmd,
    input  logic                           i_cmd_full,
    input  logic                           i_run_done,
    output logic                           o_run_pend,
    output logic                           o_wr_en,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [7:0]                     o_wr_data
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_CSUM = 4'b1000
    } t_phase;

    logic [7:0]    r_start_byte, r_ack_byte, r_nack_byte, r_len_exact;
    logic [7:0]    r_len_above, r_len_below, r_csum_seed;
    logic [15:0]   r_timeout;

    t_phase        r_phase, n_phase;
    logic [FW-1:0] r_fill, n_fill;
    logic [7:0]    r_csum, n_csum;
    logic [15:0]   r_ticks, n_ticks;
    logic [7:0]    r_len, n_len;
    logic          r_run_pend, n_run_pend;

    logic          accept;
    logic [7:0]    b;
    logic [15:0]   tick_inc;
    logic          len_ok;
    logic [sfr_pkg::RUN_W-1:0] run_n;

    assign o_full     = i_cmd_full || r_run_pend;
    assign o_run_pend = r_run_pend;
    assign accept     = i_push && !o_full;
    assign b          = i_in.rx_byte;
    assign tick_inc   = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;
    assign len_ok     = (b == r_len_exact) || ((b < r_len_below) && (b > r_len_above));
    assign run_n      = (CW'(r_fill) > CW'(sfr_pkg::RUN_MAX))
                        ? sfr_pkg::RUN_W'(sfr_pkg::RUN_MAX)
                        : sfr_pkg::RUN_W'(r_fill);

    always_comb begin
        n_phase    = r_phase;
        n_fill     = r_fill;
        n_csum     = r_csum;
        n_ticks    = r_ticks;
        n_len      = r_len;
        n_run_pend = r_run_pend && !i_run_done;
        o_cmd_push = 1'b0;
        o_cmd.ev   = sfr_pkg::EV_ERR;
        o_cmd.cnt  = '0;
        o_wr_en    = 1'b0;
        o_wr_addr  = AW'(r_fill);
        o_wr_data  = b;

        if (accept) begin
            if (i_in.action == sfr_pkg::ACT_TICK) begin
                if (r_phase != PH_IDLE) begin
                    n_ticks = tick_inc;
                    if (tick_inc >= r_timeout) begin
                        o_cmd_push = 1'b1;
                        o_cmd.ev   = sfr_pkg::EV_TIMEOUT;
                        n_phase    = PH_IDLE;
                        n_ticks    = '0;
                    end
                end
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        if (b == r_start_byte) begin
                            n_phase = PH_LEN;
                            n_ticks = '0;
                        end else if (b == r_ack_byte) begin
                            o_cmd_push = 1'b1;
                            o_cmd.ev   = sfr_pkg::EV_ACK;
                        end else if (b == r_nack_byte) begin
                            o_cmd_push = 1'b1;
                            o_cmd.ev   = sfr_pkg::EV_NACK;
                        end else begin
                            o_cmd_push = 1'b1;
                        end
                    end
                    PH_LEN: begin
                        if (len_ok) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = '0;
                            n_len     = b;
                            n_csum    = r_csum_seed;
                            n_fill    = FW'(1);
                            n_ticks   = '0;
                            n_phase   = (b <= 8'd1) ? PH_CSUM : PH_DATA;
                        end else begin
                            o_cmd_push = 1'b1;
                            n_phase    = PH_IDLE;
                        end
                    end
                    PH_DATA: begin
                        n_ticks = '0;
                        if (CW'(r_fill) >= CW'(BUFFER_DEPTH)) begin
                            o_cmd_push = 1'b1;
                            n_phase    = PH_IDLE;
                        end else begin
                            o_wr_en = 1'b1;
                            if (r_fill != '0) begin
                                n_csum = r_csum ^ b;
                            end
                            n_fill = r_fill + 1'b1;
                            if ((CW'(r_fill) + CW'(1)) >= CW'(r_len)) begin
                                n_phase = PH_CSUM;
                            end
                        end
                    end
                    PH_CSUM: begin
                        n_phase    = PH_IDLE;
                        o_cmd_push = 1'b1;
                        if (b == r_csum) begin
                            o_cmd.ev   = sfr_pkg::EV_BYTE;
                            o_cmd.cnt  = run_n;
                            n_run_pend = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_fill       <= '0;
            r_csum       <= '0;
            r_ticks      <= '0;
            r_run_pend   <= 1'b0;
            r_start_byte <= 8'd1;
            r_ack_byte   <= 8'd6;
            r_nack_byte  <= 8'd21;
            r_len_exact  <= 8'd3;
            r_len_above  <= 8'd2;
            r_len_below  <= 8'd65;
            r_csum_seed  <= 8'd255;
            r_timeout    <= 16'd150;
        end else begin
            r_phase    <= n_phase;
            r_fill     <= n_fill;
            r_csum     <= n_csum;
            r_ticks    <= n_ticks;
            r_run_pend <= n_run_pend;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sfr_pkg::CFG_START:   r_start_byte <= i_cfg_data[7:0];
                    sfr_pkg::CFG_ACK:     r_ack_byte   <= i_cfg_data[7:0];
                    sfr_pkg::CFG_NACK:    r_nack_byte  <= i_cfg_data[7:0];
                    sfr_pkg::CFG_EXACT:   r_len_exact  <= i_cfg_data[7:0];
                    sfr_pkg::CFG_ABOVE:   r_len_above  <= i_cfg_data[7:0];
                    sfr_pkg::CFG_BELOW:   r_len_below  <= i_cfg_data[7:0];
                    sfr_pkg::CFG_SEED:    r_csum_seed  <= i_cfg_data[7:0];
                    sfr_pkg::CFG_TIMEOUT: r_timeout    <= i_cfg_data;
                    default:              r_timeout    <= r_timeout;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

endmodule

// ===== rtl/sfr_back.sv =====
module sfr_back #(
    parameter int BUFFER_DEPTH = sfr_pkg::BUFFER_DEPTH_DEF,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_cmd_empty,
    input  sfr_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_run_done,
    output logic          o_empty,
    input  logic          i_pop,
    output sfr_pkg::t_out o_out
);

    logic [7:0]                 r_mem [BUFFER_DEPTH];
    logic [7:0]                 r_rd_data;
    logic [sfr_pkg::IDX_W-1:0]  r_run_idx;
    logic                       r_s1_valid;
    sfr_pkg::t_out              r_s1;
    logic                       r_out_valid;
    sfr_pkg::t_out              r_out;

    logic                       adv_out;
    logic                       s1_free;
    logic                       issue;
    logic                       is_run;
    logic                       run_last;
    logic                       rd_en;
    sfr_pkg::t_out              s1_next;
    sfr_pkg::t_out              out_next;

    assign adv_out    = r_s1_valid && (!r_out_valid || i_pop);
    assign s1_free    = !r_s1_valid || adv_out;
    assign issue      = s1_free && !i_cmd_empty;
    assign is_run     = (i_cmd.ev == sfr_pkg::EV_BYTE);
    assign run_last   = ((sfr_pkg::RUN_W'(r_run_idx) + sfr_pkg::RUN_W'(1)) == i_cmd.cnt);
    assign rd_en      = issue && is_run;
    assign o_cmd_pop  = issue && (!is_run || run_last);
    assign o_run_done = rd_en && run_last;
    assign o_empty    = !r_out_valid;
    assign o_out      = r_out;

    always_comb begin
        s1_next.event_res  = i_cmd.ev;
        s1_next.frame_byte = '0;
        s1_next.byte_index = is_run ? r_run_idx : '0;
        s1_next.last       = is_run ? run_last : 1'b1;
        out_next           = r_s1;
        if (r_s1.event_res == sfr_pkg::EV_BYTE) begin
            out_next.frame_byte = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[AW'(r_run_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_en) begin
                r_run_idx <= run_last ? '0 : r_run_idx + 1'b1;
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (adv_out) begin
                r_s1_valid <= 1'b0;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1 <= s1_next;
        end
        if (adv_out) begin
            r_out <= out_next;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH   = sfr_pkg::BUFFER_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 5_000_000;

    typedef enum logic [1:0] {RX_IDLE, RX_LEN, RX_BODY, RX_CHECK} t_rx_phase;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_push     = 1'b0;
    logic                           o_full;
    sfr_pkg::t_in                   i_in       = '0;
    logic                           o_empty;
    logic                           i_pop      = 1'b0;
    sfr_pkg::t_out                  o_out;

    // receiver copy of the register file
    logic [7:0]  cfg_start   = 8'd1;
    logic [7:0]  cfg_ack     = 8'd6;
    logic [7:0]  cfg_nack    = 8'd21;
    logic [7:0]  cfg_exact   = 8'd3;
    logic [7:0]  cfg_above   = 8'd2;
    logic [7:0]  cfg_below   = 8'd65;
    logic [7:0]  cfg_seed    = 8'hFF;
    logic [15:0] cfg_timeout = 16'd150;

    t_rx_phase   rx_phase  = RX_IDLE;
    int          fill_cnt  = 0;
    logic [7:0]  rx_sum    = '0;
    bit          rx_active = 1'b0;
    logic [15:0] idle_cnt  = '0;
    logic [7:0]  frame_mem [BUF_DEPTH];

    sfr_pkg::t_out pending_events[$];
    int   fail_cnt   = 0;
    int   cycle_cnt  = 0;
    int   byte_reqs  = 0;
    bit   tx_gaps_on = 1'b1;
    bit   rx_gaps_on = 1'b1;
    int   hold_req   = 0;
    int   hold_left  = 0;
    int   pop_wait   = 0;

    serial_frame_receiver_top uut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_push, .o_full, .i_in, .o_empty, .i_pop, .o_out
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic void emit_event(sfr_pkg::t_event ev);
        sfr_pkg::t_out r;
        r.event_res  = ev;
        r.frame_byte = '0;
        r.byte_index = '0;
        r.last       = 1'b1;
        pending_events.push_back(r);
    endfunction

    function automatic void close_frame();
        rx_phase  = RX_IDLE;
        rx_active = 1'b0;
    endfunction

    function automatic void store_frame_byte(logic [7:0] b);
        idle_cnt = '0;
        if (fill_cnt >= BUF_DEPTH) begin
            close_frame();
            emit_event(sfr_pkg::EV_ERR);
            return;
        end
        frame_mem[fill_cnt] = b;
        if (fill_cnt > 0)
            rx_sum ^= b;
        fill_cnt++;
        if (fill_cnt >= frame_mem[0])
            rx_phase = RX_CHECK;
    endfunction

    function automatic void frame_rx_step(sfr_pkg::t_in req);
        sfr_pkg::t_out r;
        int            n;
        int            i;
        logic [7:0]    b;
        b = req.rx_byte;
        if (req.action == sfr_pkg::ACT_TICK) begin
            if (!rx_active)
                return;
            if (idle_cnt != 16'hFFFF)
                idle_cnt++;
            if (idle_cnt >= cfg_timeout) begin
                close_frame();
                idle_cnt = '0;
                emit_event(sfr_pkg::EV_TIMEOUT);
            end
            return;
        end
        case (rx_phase)
            RX_IDLE: begin
                if (b == cfg_start) begin
                    rx_phase  = RX_LEN;
                    rx_active = 1'b1;
                    idle_cnt  = '0;
                end else if (b == cfg_ack) begin
                    emit_event(sfr_pkg::EV_ACK);
                end else if (b == cfg_nack) begin
                    emit_event(sfr_pkg::EV_NACK);
                end else begin
                    emit_event(sfr_pkg::EV_ERR);
                end
            end
            RX_LEN: begin
                if (b == cfg_exact || (b < cfg_below && b > cfg_above)) begin
                    fill_cnt = 0;
                    rx_sum   = cfg_seed;
                    rx_phase = RX_BODY;
                    store_frame_byte(b);
                end else begin
                    close_frame();
                    emit_event(sfr_pkg::EV_ERR);
                end
            end
            RX_BODY: store_frame_byte(b);
            default: begin
                close_frame();
                if (b != rx_sum) begin
                    emit_event(sfr_pkg::EV_ERR);
                end else begin
                    n = (fill_cnt > sfr_pkg::RUN_MAX) ? sfr_pkg::RUN_MAX : fill_cnt;
                    for (i = 0; i < n; i++) begin
                        r.event_res  = sfr_pkg::EV_BYTE;
                        r.frame_byte = frame_mem[i];
                        r.byte_index = i[sfr_pkg::IDX_W-1:0];
                        r.last       = (i == n - 1);
                        pending_events.push_back(r);
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(string label, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, label, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        sfr_pkg::t_out want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result expected none got %p", $time, o_out);
                fail_cnt++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_res", 8'(want.event_res), 8'(o_out.event_res));
                check_field("frame_byte", want.frame_byte, o_out.frame_byte);
                check_field("byte_index", 8'(want.byte_index), 8'(o_out.byte_index));
                check_field("last", 8'(want.last), 8'(o_out.last));
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            i_pop <= 1'b0;
            hold_left--;
        end else if (pop_wait > 0) begin
            i_pop <= 1'b0;
            pop_wait--;
        end else begin
            i_pop <= 1'b1;
            pop_wait = rx_gaps_on ? idle_len() : 0;
        end
    end

    task automatic send_req(sfr_pkg::t_in req);
        int g;
        i_push <= 1'b1;
        i_in   <= req;
        @(posedge i_clk);
        while (o_full)
            @(posedge i_clk);
        frame_rx_step(req);
        if (req.action == sfr_pkg::ACT_BYTE)
            byte_reqs++;
        g = tx_gaps_on ? idle_len() : 0;
        if (g > 0) begin
            i_push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(logic [7:0] b);
        sfr_pkg::t_in req;
        req.action  = sfr_pkg::ACT_BYTE;
        req.rx_byte = b;
        send_req(req);
    endtask

    task automatic send_ticks(int n);
        sfr_pkg::t_in req;
        repeat (n) begin
            req.action  = sfr_pkg::ACT_TICK;
            req.rx_byte = 8'($urandom);
            send_req(req);
        end
    endtask

    task automatic send_frame(int len, bit bad_sum, bit with_ticks);
        logic [7:0] sum;
        logic [7:0] b;
        int         body;
        sum  = cfg_seed;
        body = (len > 1) ? len - 1 : 0;
        if (body > BUF_DEPTH)
            body = BUF_DEPTH;
        send_byte(cfg_start);
        send_byte(len[7:0]);
        repeat (body) begin
            b = 8'($urandom);
            sum ^= b;
            send_byte(b);
            if (with_ticks && $urandom_range(0, 7) == 0)
                send_ticks(cfg_timeout > 6 ? $urandom_range(0, 5)
                                           : $urandom_range(0, cfg_timeout - 1));
        end
        if (bad_sum)
            sum ^= 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    task automatic drain();
        i_push <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(sfr_pkg::t_cfg_reg idx, int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= (idx == sfr_pkg::CFG_TIMEOUT) ? 16'(val) : {8'($urandom), val[7:0]};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sfr_pkg::CFG_START:   cfg_start   = val[7:0];
            sfr_pkg::CFG_ACK:     cfg_ack     = val[7:0];
            sfr_pkg::CFG_NACK:    cfg_nack    = val[7:0];
            sfr_pkg::CFG_EXACT:   cfg_exact   = val[7:0];
            sfr_pkg::CFG_ABOVE:   cfg_above   = val[7:0];
            sfr_pkg::CFG_BELOW:   cfg_below   = val[7:0];
            sfr_pkg::CFG_SEED:    cfg_seed    = val[7:0];
            sfr_pkg::CFG_TIMEOUT: cfg_timeout = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic int pick_len();
        int r;
        int lo;
        int hi;
        r  = $urandom_range(0, 99);
        lo = cfg_above + 1;
        hi = cfg_below - 1;
        if (r < 8) return $urandom_range(0, 255);
        if (r < 20 || lo > hi) return cfg_exact;
        if (r < 26) return $urandom_range(lo, hi);
        return $urandom_range(lo, (hi < lo + 10) ? hi : lo + 10);
    endfunction

    task automatic test_idle_codes();
        send_byte(cfg_ack);
        send_byte(cfg_nack);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_ticks(2);
    endtask

    task automatic test_default_frames();
        send_frame(cfg_exact, 1'b0, 1'b0);
        send_frame(4, 1'b1, 1'b0);
        send_byte(cfg_start);
        send_byte(cfg_above);
        send_byte(cfg_start);
        send_byte(cfg_below);
        drain();
    endtask

    task automatic test_short_lengths();
        drain();
        write_reg(sfr_pkg::CFG_EXACT, 0);
        write_reg(sfr_pkg::CFG_ABOVE, 0);
        send_frame(0, 1'b0, 1'b0);
        send_frame(1, 1'b0, 1'b0);
        send_frame(1, 1'b1, 1'b0);
        drain();
    endtask

    task automatic test_code_overlap();
        drain();
        write_reg(sfr_pkg::CFG_START, 8'h5A);
        write_reg(sfr_pkg::CFG_ACK, 8'h5A);
        write_reg(sfr_pkg::CFG_NACK, 8'h5A);
        send_byte(8'h5A);
        send_byte(8'h5A);
        drain();
        write_reg(sfr_pkg::CFG_START, 8'h00);
        send_byte(8'h5A);
        drain();
        write_reg(sfr_pkg::CFG_NACK, 8'hFF);
        send_byte(8'hFF);
        send_frame(0, 1'b0, 1'b0);
        drain();
        write_reg(sfr_pkg::CFG_START, 1);
        write_reg(sfr_pkg::CFG_ACK, 6);
        write_reg(sfr_pkg::CFG_NACK, 21);
    endtask

    task automatic test_timeouts();
        logic [7:0] b1;
        logic [7:0] b2;
        drain();
        write_reg(sfr_pkg::CFG_TIMEOUT, 1);
        send_byte(cfg_start);
        send_ticks(1);
        drain();
        write_reg(sfr_pkg::CFG_TIMEOUT, 4);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        send_byte(cfg_start);
        send_ticks(3);
        send_byte(8'd3);
        send_ticks(3);
        send_byte(b1);
        send_ticks(3);
        send_byte(b2);
        send_ticks(3);
        send_byte(cfg_seed ^ b1 ^ b2);
        send_byte(cfg_start);
        send_byte(8'd3);
        send_ticks(4);
        send_ticks(2);
        // checksum byte does not restart the timer
        send_byte(cfg_start);
        send_byte(8'd0);
        send_ticks(3);
        send_byte(cfg_seed);
        send_byte(cfg_start);
        send_byte(8'd0);
        send_ticks(4);
        drain();
        write_reg(sfr_pkg::CFG_TIMEOUT, 65535);
        send_frame(5, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_overflow();
        drain();
        write_reg(sfr_pkg::CFG_BELOW, 255);
        write_reg(sfr_pkg::CFG_SEED, 0);
        send_frame(200, 1'b0, 1'b0);
        drain();
        write_reg(sfr_pkg::CFG_EXACT, 255);
        write_reg(sfr_pkg::CFG_ABOVE, 255);
        write_reg(sfr_pkg::CFG_BELOW, 0);
        send_byte(cfg_start);
        send_byte(8'd100);
        drain();
    endtask

    task automatic test_backpressure();
        drain();
        write_reg(sfr_pkg::CFG_EXACT, 3);
        write_reg(sfr_pkg::CFG_ABOVE, 2);
        write_reg(sfr_pkg::CFG_BELOW, 65);
        write_reg(sfr_pkg::CFG_SEED, $urandom_range(0, 255));
        write_reg(sfr_pkg::CFG_TIMEOUT, 150);
        tx_gaps_on = 1'b0;
        hold_req   = 600;
        repeat (8) send_byte(cfg_ack);
        send_frame(64, 1'b0, 1'b0);
        repeat (4) send_byte(cfg_nack);
        // sender waits for every result before going on
        drain();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int p;
        int r;
        int target;
        int below;
        for (p = 0; p < 4; p++) begin
            drain();
            if (p < 3) begin
                write_reg(sfr_pkg::CFG_START, $urandom_range(0, 255));
                write_reg(sfr_pkg::CFG_ACK, $urandom_range(0, 255));
                write_reg(sfr_pkg::CFG_NACK, $urandom_range(0, 255));
                write_reg(sfr_pkg::CFG_EXACT, $urandom_range(0, 70));
                write_reg(sfr_pkg::CFG_ABOVE, $urandom_range(0, 10));
                below = $urandom_range(cfg_above + 2, 100);
                write_reg(sfr_pkg::CFG_BELOW, below);
                write_reg(sfr_pkg::CFG_SEED, $urandom_range(0, 255));
                write_reg(sfr_pkg::CFG_TIMEOUT, $urandom_range(3, 30));
            end else begin
                write_reg(sfr_pkg::CFG_START, 255);
                write_reg(sfr_pkg::CFG_ACK, 0);
                write_reg(sfr_pkg::CFG_NACK, 128);
                write_reg(sfr_pkg::CFG_EXACT, 1);
                write_reg(sfr_pkg::CFG_ABOVE, 0);
                write_reg(sfr_pkg::CFG_BELOW, 255);
                write_reg(sfr_pkg::CFG_SEED, 255);
                write_reg(sfr_pkg::CFG_TIMEOUT, 65535);
            end
            tx_gaps_on = (p != 1);
            rx_gaps_on = (p != 2);
            target = byte_reqs + 6;
            while (byte_reqs < target) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    send_frame(pick_len(), $urandom_range(0, 9) == 0, 1'b1);
                end else if (r < 78) begin
                    send_byte(cfg_start);
                    send_byte(8'(pick_len()));
                    repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
                    if (cfg_timeout <= 64)
                        send_ticks(cfg_timeout);
                end else if (r < 86) begin
                    send_byte($urandom_range(0, 1) ? cfg_ack : cfg_nack);
                end else if (r < 93) begin
                    send_byte(8'($urandom));
                end else begin
                    send_ticks($urandom_range(1, 4));
                end
            end
        end
        drain();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_codes();
        test_default_frames();
        test_short_lengths();
        test_code_overlap();
        test_timeouts();
        test_overflow();
        test_backpressure();
        test_random_traffic();
        drain();
        if (fail_cnt == 0 && pending_events.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sfr_pkg.sv
rtl/sfr_cmd_fifo.sv
rtl/sfr_front.sv
rtl/sfr_back.sv
rtl/serial_frame_receiver_top.sv
tb/tb_top.sv
